@@ rtl/kcl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcl_pkg: shared types and constants of the keypad code lock
// Command, status and phase codes, key codes, register indexes and reset
// values used by the lock engine and the top level.
// ----------------------------------------------------------------------------
package kcl_pkg;

	// default code length in digits
	localparam int CODE_LEN_DEF = 4;

	// register reset values
	localparam logic [3:0]  MAX_WRONG_RST  = 4'd3;
	localparam logic [15:0] LOCK_TICKS_RST = 16'd30000;

	// key codes
	localparam logic [7:0] KEY_CANCEL = 8'h44;  // 'D'
	localparam logic [7:0] KEY_ZERO   = 8'h30;  // '0'
	localparam logic [7:0] KEY_NINE   = 8'h39;  // '9'

	typedef enum logic [1:0] {
		CMD_KEY          = 2'd0,
		CMD_TICK         = 2'd1,
		CMD_BEGIN_AUTH   = 2'd2,
		CMD_BEGIN_CHANGE = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		ST_NONE          = 4'd0,
		ST_DIGIT         = 4'd1,
		ST_IGNORED       = 4'd2,
		ST_GRANTED       = 4'd3,
		ST_DENIED        = 4'd4,
		ST_BECAME_LOCKED = 4'd5,
		ST_REFUSED       = 4'd6,
		ST_CANCELLED     = 4'd7,
		ST_CHANGE_DENIED = 4'd8,
		ST_CODE_SET      = 4'd9,
		ST_MISMATCH      = 4'd10,
		ST_UNLOCKED      = 4'd11,
		ST_STARTED       = 4'd12
	} status_t;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_AUTH    = 3'd1,
		PH_OLD     = 3'd2,
		PH_NEW     = 3'd3,
		PH_CONFIRM = 3'd4
	} phase_t;

	typedef enum logic [0:0] {
		CFG_MAX_WRONG  = 1'b0,
		CFG_LOCK_TICKS = 1'b1
	} cfg_idx_t;

	// configuration seen by the engine
	typedef struct packed {
		logic [3:0]  max_wrong;
		logic [15:0] lock_ticks;
	} cfg_t;

	// one request as it enters the engine
	typedef struct packed {
		cmd_t       command;
		logic [7:0] key;
	} req_t;

	// one result item
	typedef struct packed {
		status_t    status;
		logic [2:0] digits_entered;
		logic [3:0] tries_left;
		logic       locked;
		phase_t     phase;
	} result_t;

endpackage

@@ rtl/kcl_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcl_engine: session state and code compare of the keypad code lock
// Holds stored code, entry buffers, counters and lockout countdown. Each
// step applies one request and gives its result in the same cycle.
// ----------------------------------------------------------------------------
module kcl_engine #(
	parameter int CODE_LEN = kcl_pkg::CODE_LEN_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  kcl_pkg::req_t     req,
	input  kcl_pkg::cfg_t     cfg,
	output kcl_pkg::result_t  result
);
	import kcl_pkg::*;

	localparam int CNT_W = (CODE_LEN > 1) ? $clog2(CODE_LEN) : 1;
	localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(CODE_LEN - 1);

	// state
	logic [CODE_LEN-1:0][3:0] stored_q, stored_d;
	logic [CODE_LEN-1:0][3:0] entry_q, entry_full;
	logic [CODE_LEN-1:0][3:0] new_code_q;
	logic [CNT_W-1:0]         cnt_q, cnt_d;
	logic [3:0]               wrong_q, wrong_d, wrong_inc;
	logic [15:0]              remain_q, remain_d;
	logic                     lock_q, lock_d;
	phase_t                   phase_q, phase_d;
	logic                     entry_we, new_code_we;
	logic [3:0]               digit;
	logic                     is_digit;
	logic                     match_stored, match_new;
	status_t                  st;

	// entry with the current digit put in place
	assign digit    = 4'(req.key - KEY_ZERO);
	assign is_digit = (req.key >= KEY_ZERO) && (req.key <= KEY_NINE);

	always_comb begin
		for (int i = 0; i < CODE_LEN; i++) begin
			entry_full[i] = (cnt_q == CNT_W'(i)) ? digit : entry_q[i];
		end
	end

	assign match_stored = (entry_full == stored_q);
	assign match_new    = (entry_full == new_code_q);
	assign wrong_inc    = (wrong_q == 4'hf) ? wrong_q : wrong_q + 4'd1;

	// next state and status
	always_comb begin
		stored_d    = stored_q;
		cnt_d       = cnt_q;
		wrong_d     = wrong_q;
		remain_d    = remain_q;
		lock_d      = lock_q;
		phase_d     = phase_q;
		entry_we    = 1'b0;
		new_code_we = 1'b0;
		st          = ST_NONE;
		unique case (req.command)
			CMD_KEY: begin
				if (lock_q) begin
					st = ST_REFUSED;
				end else if (phase_q == PH_IDLE) begin
					st = ST_IGNORED;
				end else if (req.key == KEY_CANCEL) begin
					phase_d = PH_IDLE;
					cnt_d   = '0;
					st      = ST_CANCELLED;
				end else if (is_digit) begin
					entry_we = 1'b1;
					st       = ST_DIGIT;
					if (cnt_q != LAST_IDX) begin
						cnt_d = cnt_q + CNT_W'(1);
					end else begin
						// entry complete
						cnt_d = '0;
						unique case (phase_q)
							PH_AUTH: begin
								phase_d = PH_IDLE;
								if (match_stored) begin
									wrong_d = '0;
									st      = ST_GRANTED;
								end else begin
									wrong_d = wrong_inc;
									if (wrong_inc >= cfg.max_wrong) begin
										lock_d   = 1'b1;
										remain_d = cfg.lock_ticks;
										st       = ST_BECAME_LOCKED;
									end else begin
										st = ST_DENIED;
									end
								end
							end
							PH_OLD: begin
								if (match_stored) begin
									phase_d = PH_NEW;
								end else begin
									phase_d = PH_IDLE;
									st      = ST_CHANGE_DENIED;
								end
							end
							PH_NEW: begin
								new_code_we = 1'b1;
								phase_d     = PH_CONFIRM;
							end
							default: begin
								if (match_new) begin
									stored_d = new_code_q;
									st       = ST_CODE_SET;
								end else begin
									st = ST_MISMATCH;
								end
								phase_d = PH_IDLE;
							end
						endcase
					end
				end else begin
					st = ST_IGNORED;
				end
			end
			CMD_TICK: begin
				// lockout countdown
				if (lock_q) begin
					if (remain_q <= 16'd1) begin
						remain_d = '0;
						lock_d   = 1'b0;
						wrong_d  = '0;
						st       = ST_UNLOCKED;
					end else begin
						remain_d = remain_q - 16'd1;
					end
				end
			end
			default: begin
				if (lock_q) begin
					st = ST_REFUSED;
				end else begin
					phase_d = (req.command == CMD_BEGIN_AUTH) ? PH_AUTH : PH_OLD;
					cnt_d   = '0;
					st      = ST_STARTED;
				end
			end
		endcase
	end

	// result fields from the state after the step
	always_comb begin
		result.status         = st;
		result.digits_entered = 3'(cnt_d);
		result.tries_left     = (wrong_d >= cfg.max_wrong) ? 4'd0 : cfg.max_wrong - wrong_d;
		result.locked         = lock_d;
		result.phase          = phase_d;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CODE_LEN; i++) begin
				stored_q[i] <= 4'(i + 1);
			end
			cnt_q    <= '0;
			wrong_q  <= '0;
			remain_q <= '0;
			lock_q   <= 1'b0;
			phase_q  <= PH_IDLE;
		end else if (step) begin
			stored_q <= stored_d;
			cnt_q    <= cnt_d;
			wrong_q  <= wrong_d;
			remain_q <= remain_d;
			lock_q   <= lock_d;
			phase_q  <= phase_d;
		end
	end

	// entry buffers, written before they are read in a session
	always_ff @(posedge clk) begin
		if (step && entry_we) begin
			entry_q <= entry_full;
		end
		if (step && new_code_we) begin
			new_code_q <= entry_full;
		end
	end

endmodule

@@ rtl/keypad_code_lock_with_lockout_unit.sv @@
`timescale 1ns / 1ps
// a request passes the input stage, then the result register, which waits on out_ready
// throughput: one request per cycle unless a waiting result is not taken; the engine updates state per request
// the input stage takes a new request while the last result waits, if the input stage is empty
// reset: asynchronous, clears session, counters and lockout; stored code 1,2,...
// configuration returns to 3 wrong attempts and 30000 lockout ticks
// ----------------------------------------------------------------------------
// keypad_code_lock_with_lockout_unit: keypad code lock with lockout
// Authentication and code change sessions over key requests, with a
// wrong-attempt counter and a tick driven lockout countdown.
// ----------------------------------------------------------------------------
module keypad_code_lock_with_lockout_unit #(
	parameter int CODE_LEN = kcl_pkg::CODE_LEN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// request channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  command,
	input  logic [7:0]  key,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  status,
	output logic [2:0]  digits_entered,
	output logic [3:0]  tries_left,
	output logic        locked,
	output logic [2:0]  phase
);
	import kcl_pkg::*;

	logic    valid_s1;
	req_t    req_s1;
	logic    advance;
	cfg_t    cfg_q;
	result_t res_next;
	result_t res_q;
	logic    out_valid_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_wrong  <= MAX_WRONG_RST;
			cfg_q.lock_ticks <= LOCK_TICKS_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_MAX_WRONG:  cfg_q.max_wrong  <= cfg_data[3:0];
				CFG_LOCK_TICKS: cfg_q.lock_ticks <= cfg_data;
			endcase
		end
	end

	// handshake
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_s1.command <= cmd_t'(command);
			req_s1.key     <= key;
		end
	end

	kcl_engine #(
		.CODE_LEN (CODE_LEN)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.req    (req_s1),
		.cfg    (cfg_q),
		.result (res_next)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_next;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = res_q.status;
	assign digits_entered = res_q.digits_entered;
	assign tries_left     = res_q.tries_left;
	assign locked         = res_q.locked;
	assign phase          = res_q.phase;

	// checks
	a_lock_shown: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_BECAME_LOCKED) |-> locked && (tries_left == 4'd0))
		else $error("lockout result without lock flag");

	a_unlock_shown: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_UNLOCKED) |-> !locked)
		else $error("unlock result with lock flag set");

	a_start_shown: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_STARTED) |->
		(digits_entered == 3'd0) && (phase != PH_IDLE) && !locked)
		else $error("entry start result with wrong session fields");

	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && !out_ready |-> !in_ready)
		else $error("request taken while both stages are full");

endmodule
